/* src/bps_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bps_pkg: shared types and codes for the battery precharge sequencer
// Phase and request codes, register indexes, the config bundle and the
// classified tick that travels from the front to the back.
// ============================================================================
package bps_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PACK    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUPPLY_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUPPLY_HIGH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUS_MSG_ID  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_MIN_PACK    = 16'd0;
    localparam logic [15:0] RST_TIMEOUT     = 16'd5000;
    localparam logic [15:0] RST_SUPPLY_LOW  = 16'd11000;
    localparam logic [15:0] RST_SUPPLY_HIGH = 16'd15000;
    localparam logic [10:0] RST_BUS_MSG_ID  = 11'h682;

    // Phase codes as seen on the result
    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_ACTIVE   = 2'd1;
    localparam logic [1:0] PHASE_COMPLETE = 2'd2;
    localparam logic [1:0] PHASE_FAULT    = 2'd3;

    // Request codes
    localparam logic [1:0] REQ_NONE        = 2'd0;
    localparam logic [1:0] REQ_PRECHARGING = 2'd1;
    localparam logic [1:0] REQ_ACTIVE      = 2'd2;
    localparam logic [1:0] REQ_FAULT       = 2'd3;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_ACTIVE   = 4'b0010,
        ST_COMPLETE = 4'b0100,
        ST_FAULT    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [15:0] min_pack_voltage;
        logic [15:0] timeout_ms;
        logic [15:0] supply_low_mv;
        logic [15:0] supply_high_mv;
        logic [10:0] bus_msg_id;
    } cfg_t;

    // One tick after classification
    typedef struct packed {
        logic        permit_base;   // shutdown closed, no fault, supply in window
        logic        reached;       // bus at or above 90% of pack
        logic        pack_ok;       // pack at or above the start minimum
        logic        shut_closed;
        logic [9:0]  elapsed_ms;
        logic [15:0] bus_voltage;
    } tick_t;

endpackage

/* src/bps_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// bps_queue: short register FIFO
// Decouples the classifying front from the phase machine in the back.
// ============================================================================
module bps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/bps_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// bps_front: tick intake and classification
// Latches the bus voltage from matching messages and reduces each tick to
// the few conditions the phase machine needs.
// ============================================================================
module bps_front (
    input  logic           clk,
    input  logic           rst_n,
    input  bps_pkg::cfg_t  cfg,
    input  logic           in_valid,
    input  logic           queue_full,
    input  logic           msg_valid,
    input  logic [10:0]    msg_id,
    input  logic [7:0]     msg_byte2,
    input  logic [7:0]     msg_byte3,
    input  logic           charger_present,
    input  logic [15:0]    pack_voltage,
    input  logic [15:0]    supply_mv,
    input  logic           shutdown_closed,
    input  logic           bms_fault,
    input  logic [9:0]     elapsed_ms,
    output logic           in_stall,
    output logic           push,
    output bps_pkg::tick_t tick
);
    logic [15:0] bus_voltage_reg, bus_voltage_next;
    logic [19:0] bus_x10;
    logic [19:0] pack_x9;
    logic        supply_ok;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        bus_voltage_next = bus_voltage_reg;
        if (msg_valid && !charger_present && (msg_id == cfg.bus_msg_id))
        begin
            bus_voltage_next = {msg_byte3, msg_byte2};
        end
    end

    // 10*bus against 9*pack: exact form of the 90% threshold
    assign bus_x10 = {1'b0, bus_voltage_next, 3'b000} + {3'b000, bus_voltage_next, 1'b0};
    assign pack_x9 = {1'b0, pack_voltage, 3'b000} + {4'b0000, pack_voltage};

    assign supply_ok = (supply_mv > cfg.supply_low_mv) && (supply_mv < cfg.supply_high_mv);

    always_comb
    begin
        tick.permit_base = shutdown_closed && !bms_fault && supply_ok;
        tick.reached     = (bus_x10 >= pack_x9);
        tick.pack_ok     = (pack_voltage >= cfg.min_pack_voltage);
        tick.shut_closed = shutdown_closed;
        tick.elapsed_ms  = elapsed_ms;
        tick.bus_voltage = bus_voltage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_voltage_reg <= '0;
        end
        else if (push)
        begin
            bus_voltage_reg <= bus_voltage_next;
        end
    end

endmodule

/* src/bps_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// bps_back: precharge phase machine and result register
// Pops one classified tick per cycle unless the queue is empty or the result
// stalls, steps the phase machine and holds the result until it is taken.
// ============================================================================
module bps_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bps_pkg::cfg_t  cfg,
    input  logic           queue_empty,
    input  bps_pkg::tick_t tick,
    input  logic           out_stall,
    output logic           pop,
    output logic           out_valid,
    output logic           relay_drive_n,
    output logic           precharging,
    output logic           precharge_done,
    output logic [1:0]     phase,
    output logic [1:0]     bms_request,
    output logic [15:0]    bus_voltage
);
    bps_pkg::phase_t state_reg, state_next;
    logic [15:0] timer_reg, timer_next;
    logic        relay_reg, relay_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [1:0]  req;
    logic [1:0]  phase_code;
    logic [16:0] timer_sum;
    logic [15:0] timer_sat;
    logic        permit;

    logic        out_valid_reg;
    logic        out_relay_reg, out_run_reg, out_done_reg;
    logic [1:0]  out_phase_reg, out_req_reg;
    logic [15:0] out_bus_reg;

    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    assign permit    = tick.permit_base && !tick.reached;
    assign timer_sum = {1'b0, timer_reg} + {7'b0, tick.elapsed_ms};
    assign timer_sat = timer_sum[16] ? bps_pkg::TIMER_MAX : timer_sum[15:0];

    always_comb
    begin
        state_next = state_reg;
        timer_next = timer_reg;
        relay_next = relay_reg;
        run_next   = run_reg;
        done_next  = done_reg;
        req        = bps_pkg::REQ_NONE;
        case (state_reg)
            bps_pkg::ST_IDLE:
            begin
                run_next = 1'b0;
                if (permit && tick.pack_ok)
                begin
                    relay_next = 1'b0;
                    run_next   = 1'b1;
                    req        = bps_pkg::REQ_PRECHARGING;
                    timer_next = '0;
                    state_next = bps_pkg::ST_ACTIVE;
                end
            end
            bps_pkg::ST_ACTIVE:
            begin
                timer_next = timer_sat;
                if (!permit)
                begin
                    relay_next = 1'b1;
                    run_next   = 1'b0;
                    done_next  = 1'b0;
                    timer_next = '0;
                    state_next = bps_pkg::ST_FAULT;
                end
                else if (tick.reached)
                begin
                    relay_next = 1'b1;
                    run_next   = 1'b0;
                    done_next  = 1'b1;
                    req        = bps_pkg::REQ_ACTIVE;
                    state_next = bps_pkg::ST_COMPLETE;
                end
                else if (timer_sat > cfg.timeout_ms)
                begin
                    relay_next = 1'b1;
                    run_next   = 1'b0;
                    done_next  = 1'b0;
                    timer_next = '0;
                    req        = bps_pkg::REQ_FAULT;
                    state_next = bps_pkg::ST_FAULT;
                end
            end
            bps_pkg::ST_COMPLETE:
            begin
                if (!permit)
                begin
                    state_next = bps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                relay_next = 1'b1;
                run_next   = 1'b0;
                done_next  = 1'b0;
                if (!tick.shut_closed)
                begin
                    state_next = bps_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        case (state_next)
            bps_pkg::ST_IDLE:     phase_code = bps_pkg::PHASE_IDLE;
            bps_pkg::ST_ACTIVE:   phase_code = bps_pkg::PHASE_ACTIVE;
            bps_pkg::ST_COMPLETE: phase_code = bps_pkg::PHASE_COMPLETE;
            default:              phase_code = bps_pkg::PHASE_FAULT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bps_pkg::ST_IDLE;
            timer_reg     <= '0;
            relay_reg     <= 1'b1;
            run_reg       <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                timer_reg <= timer_next;
                relay_reg <= relay_next;
                run_reg   <= run_next;
                done_reg  <= done_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_relay_reg <= relay_next;
            out_run_reg   <= run_next;
            out_done_reg  <= done_next;
            out_phase_reg <= phase_code;
            out_req_reg   <= req;
            out_bus_reg   <= tick.bus_voltage;
        end
    end

    assign out_valid      = out_valid_reg;
    assign relay_drive_n  = out_relay_reg;
    assign precharging    = out_run_reg;
    assign precharge_done = out_done_reg;
    assign phase          = out_phase_reg;
    assign bms_request    = out_req_reg;
    assign bus_voltage    = out_bus_reg;

endmodule

/* src/battery_precharge_sequencer.sv */
`timescale 1ns / 1ps
// ============================================================================
// battery_precharge_sequencer: precharge relay sequencing per update tick
// Front classifier, short queue and phase machine with a result register.
// ============================================================================
// Each input beat is one update tick and yields exactly one result beat. The
// block takes one beat per clock cycle and delivers one per cycle while
// nothing stalls; a tick passes a queue register and the result register
// in turn before its beat turns valid. The back's phase machine sets the
// rate; it steps once per tick. The front latches the DC bus voltage from a
// matching message (unless a charger is present) and reduces the tick to a
// handful of conditions; a queue of QUEUE_DEPTH entries sits between front
// and back so an output stall fills the queue before it stalls the input.
// Write the configuration registers only while no tick is in flight; a write
// to an index above the last register is dropped. No clearing pass after reset.
// ============================================================================
module battery_precharge_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data,
    // tick input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            msg_valid,
    input  logic [10:0]                     msg_id,
    input  logic [7:0]                      msg_byte2,
    input  logic [7:0]                      msg_byte3,
    input  logic                            charger_present,
    input  logic [15:0]                     pack_voltage,
    input  logic [15:0]                     supply_mv,
    input  logic                            shutdown_closed,
    input  logic                            bms_fault,
    input  logic [9:0]                      elapsed_ms,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            relay_drive_n,
    output logic                            precharging,
    output logic                            precharge_done,
    output logic [1:0]                      phase,
    output logic [1:0]                      bms_request,
    output logic [15:0]                     bus_voltage
);
    localparam int TICK_W = $bits(bps_pkg::tick_t);

    bps_pkg::cfg_t  cfg_reg;
    bps_pkg::tick_t front_tick;
    bps_pkg::tick_t back_tick;
    logic [TICK_W-1:0] queue_out;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // Hold configuration; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pack_voltage <= bps_pkg::RST_MIN_PACK;
            cfg_reg.timeout_ms       <= bps_pkg::RST_TIMEOUT;
            cfg_reg.supply_low_mv    <= bps_pkg::RST_SUPPLY_LOW;
            cfg_reg.supply_high_mv   <= bps_pkg::RST_SUPPLY_HIGH;
            cfg_reg.bus_msg_id       <= bps_pkg::RST_BUS_MSG_ID;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bps_pkg::CFG_MIN_PACK:    cfg_reg.min_pack_voltage <= cfg_data;
                bps_pkg::CFG_TIMEOUT:     cfg_reg.timeout_ms       <= cfg_data;
                bps_pkg::CFG_SUPPLY_LOW:  cfg_reg.supply_low_mv    <= cfg_data;
                bps_pkg::CFG_SUPPLY_HIGH: cfg_reg.supply_high_mv   <= cfg_data;
                bps_pkg::CFG_BUS_MSG_ID:  cfg_reg.bus_msg_id       <= cfg_data[10:0];
                default:                  ;
            endcase
        end
    end

    // Front: latch bus voltage, classify the tick
    bps_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .queue_full      (queue_full),
        .msg_valid       (msg_valid),
        .msg_id          (msg_id),
        .msg_byte2       (msg_byte2),
        .msg_byte3       (msg_byte3),
        .charger_present (charger_present),
        .pack_voltage    (pack_voltage),
        .supply_mv       (supply_mv),
        .shutdown_closed (shutdown_closed),
        .bms_fault       (bms_fault),
        .elapsed_ms      (elapsed_ms),
        .in_stall        (in_stall),
        .push            (push),
        .tick            (front_tick)
    );

    // Queue: absorb output stalls
    bps_queue #(
        .WIDTH (TICK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_tick),
        .pop       (pop),
        .pop_data  (queue_out),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    assign back_tick = bps_pkg::tick_t'(queue_out);

    // Back: advance the phase machine, register the result beat
    bps_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .queue_empty    (queue_empty),
        .tick           (back_tick),
        .out_stall      (out_stall),
        .pop            (pop),
        .out_valid      (out_valid),
        .relay_drive_n  (relay_drive_n),
        .precharging    (precharging),
        .precharge_done (precharge_done),
        .phase          (phase),
        .bms_request    (bms_request),
        .bus_voltage    (bus_voltage)
    );

`ifndef SYNTHESIS
    // The relay is driven exactly while precharge runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (relay_drive_n != precharging))
        else $error("relay level and running flag disagree");

    // A running precharge is only reported in the active phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && precharging) |-> (phase == bps_pkg::PHASE_ACTIVE))
        else $error("precharging outside the active phase");

    // A start request always lands in the active phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (bms_request == bps_pkg::REQ_PRECHARGING))
            |-> (phase == bps_pkg::PHASE_ACTIVE))
        else $error("start request without entering active");

    // The back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("pop from an empty queue");
`endif

endmodule
